/* rtl/assert_macros.svh */
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define CAL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define CAL_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define CAL_ASSERT(label, prop, msg)

`define CAL_NEVER(label, cond, msg)

`endif

`endif

/* rtl/cal_pkg.sv */
package cal_pkg;

  localparam int WORD_BITS = 32;
  localparam int LEN_BITS  = 7;
  localparam int DEPTH_DEF = 64;
  localparam logic [LEN_BITS-1:0] CAP_RESET = 7'd64;

  typedef enum logic [3:0] {
    K_INSERT  = 4'd0,
    K_APPEND  = 4'd1,
    K_REMOVE  = 4'd2,
    K_START   = 4'd3,
    K_END     = 4'd4,
    K_BACK    = 4'd5,
    K_FORWARD = 4'd6,
    K_SEEK    = 4'd7,
    K_GET     = 4'd8,
    K_CLEAR   = 4'd9
  } cal_kind_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_NONE  = 2'd2,
    ERR_RANGE = 2'd3
  } cal_err_e;

  // broadcast to every cell
  typedef struct packed {
    logic                 ins;
    logic                 app;
    logic                 rem;
    logic [LEN_BITS-1:0]  cursor;
    logic [LEN_BITS-1:0]  count;
    logic [WORD_BITS-1:0] value;
  } cal_ctrl_t;

  // result fields except the word
  typedef struct packed {
    cal_err_e            err;
    logic [LEN_BITS-1:0] length;
    logic [LEN_BITS-1:0] cursor;
    logic                rd_ok;
  } cal_res_t;

endpackage

/* rtl/cal_cell.sv */
module cal_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk_i,
  input  cal_pkg::cal_ctrl_t            ctrl_i,
  input  logic [cal_pkg::WORD_BITS-1:0] left_i,
  input  logic [cal_pkg::WORD_BITS-1:0] right_i,
  output logic [cal_pkg::WORD_BITS-1:0] word_o
);
  import cal_pkg::*;

  logic [WORD_BITS-1:0] word_q, word_d;
  int cur, cnt;

  always_comb begin
    cur    = int'(ctrl_i.cursor);
    cnt    = int'(ctrl_i.count);
    word_d = word_q;
    if (ctrl_i.ins && IDX == cur) begin
      word_d = ctrl_i.value;
    end else if (ctrl_i.ins && IDX > cur && IDX <= cnt) begin
      word_d = left_i;
    end else if (ctrl_i.app && IDX == cnt) begin
      word_d = ctrl_i.value;
    end else if (ctrl_i.rem && IDX >= cur && IDX + 1 < cnt) begin
      word_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

/* rtl/cal_ctrl.sv */
`include "assert_macros.svh"

module cal_ctrl #(
  parameter int DEPTH = cal_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic [3:0]                    kind_i,
  input  logic [cal_pkg::WORD_BITS-1:0] value_i,
  input  logic [cal_pkg::LEN_BITS-1:0]  position_i,
  input  logic                          cfg_we_i,
  input  logic [cal_pkg::LEN_BITS-1:0]  cfg_wdata_i,
  output cal_pkg::cal_ctrl_t            ctrl_o,
  output cal_pkg::cal_res_t             res_o
);
  import cal_pkg::*;

  localparam int LimInt = (DEPTH > 127) ? 127 : DEPTH;
  localparam logic [LEN_BITS-1:0] DepthLim = LEN_BITS'(LimInt);

  logic [LEN_BITS-1:0] count_q, count_d, cursor_q, cursor_d, cap_q, lim;
  logic     ins, app, rem, rd_ok, full, has;
  cal_err_e err;

  assign lim  = (cap_q < DepthLim) ? cap_q : DepthLim;
  assign full = count_q >= lim;
  assign has  = cursor_q < count_q;

  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    err      = ERR_OK;
    ins      = 1'b0;
    app      = 1'b0;
    rem      = 1'b0;
    rd_ok    = 1'b0;
    unique case (cal_kind_e'(kind_i))
      K_INSERT: begin
        if (full) begin
          err = ERR_FULL;
        end else begin
          ins     = 1'b1;
          count_d = count_q + 7'd1;
        end
      end
      K_APPEND: begin
        if (full) begin
          err = ERR_FULL;
        end else begin
          app     = 1'b1;
          count_d = count_q + 7'd1;
        end
      end
      K_REMOVE: begin
        if (!has) begin
          err = ERR_NONE;
        end else begin
          rem     = 1'b1;
          rd_ok   = 1'b1;
          count_d = count_q - 7'd1;
        end
      end
      K_START: cursor_d = '0;
      K_END:   cursor_d = count_q;
      K_BACK: begin
        if (cursor_q != '0) cursor_d = cursor_q - 7'd1;
      end
      K_FORWARD: begin
        if (has) cursor_d = cursor_q + 7'd1;
      end
      K_SEEK: begin
        if (position_i > count_q) err = ERR_RANGE;
        else cursor_d = position_i;
      end
      K_GET: begin
        if (!has) err = ERR_NONE;
        else rd_ok = 1'b1;
      end
      K_CLEAR: begin
        count_d  = '0;
        cursor_d = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    ctrl_o.ins    = fire_i & ins;
    ctrl_o.app    = fire_i & app;
    ctrl_o.rem    = fire_i & rem;
    ctrl_o.cursor = cursor_q;
    ctrl_o.count  = count_q;
    ctrl_o.value  = value_i;
    res_o.err     = err;
    res_o.length  = count_d;
    res_o.cursor  = cursor_d;
    res_o.rd_ok   = rd_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
      cap_q    <= CAP_RESET;
    end else begin
      if (fire_i) begin
        count_q  <= count_d;
        cursor_q <= cursor_d;
      end
      if (cfg_we_i) cap_q <= cfg_wdata_i;
    end
  end

  `CAL_NEVER(a_cursor_in_list, cursor_q > count_q, "cursor beyond length")
  `CAL_NEVER(a_count_in_depth, count_q > DepthLim, "length beyond depth")
  `CAL_ASSERT(a_idle_holds, !fire_i |=> $stable(count_q) && $stable(cursor_q), "state moved")
  `CAL_ASSERT(a_full_refused, fire_i && full && (ins || app) |-> 1'b0, "write to full list")
  `CAL_ASSERT(a_grow_bounded, fire_i && count_q < lim |=> count_q <= $past(lim), "grew past limit")

endmodule

/* rtl/cursor_array_list.sv */
// channel   dir  tdata                                  tuser
// s_axis    in   value[31:0] position[38:32] pad      kind[3:0]
// m_axis    out  data[31:0] error[33:32] length[40:34] cursor[47:41]  -
// cfg       in   capacity[6:0] on cfg_we_i            -
// one beat per cycle unless stalled: every operation, insert and remove included,
// runs in the cycle it is accepted, cells shifting together toward their neighbor
// the result sits in one output register, loaded when the beat is accepted
// s_axis_tready drops only while a result waits and m_axis_tready is low
// reset clears length, cursor and output valid and sets capacity to 64; cells need none
module cursor_array_list #(
  parameter int DEPTH = cal_pkg::DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // value, position, pad
  input  logic [3:0]  s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // data, error, length, cursor
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i
);
  import cal_pkg::*;

  logic fire, m_valid_q;
  logic [47:0] m_data_q;
  cal_ctrl_t ctrl;
  cal_res_t  res;
  logic [WORD_BITS-1:0] words [DEPTH];
  logic [WORD_BITS-1:0] rd_word, out_word;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  cal_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .kind_i     (s_axis_tuser),
    .value_i    (s_axis_tdata[31:0]),
    .position_i (s_axis_tdata[38:32]),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .ctrl_o     (ctrl),
    .res_o      (res)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = words[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = words[g+1];
    end
    cal_cell #(.IDX(g)) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .left_i (left_w),
      .right_i(right_w),
      .word_o (words[g])
    );
  end

  // word under the cursor
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (i == int'(ctrl.cursor)) rd_word = rd_word | words[i];
    end
  end

  assign out_word = res.rd_ok ? rd_word : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) m_data_q <= {res.cursor, res.length, res.err, out_word};
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
